@@ hw/rtl/assert_macros.svh @@
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// implication or expression checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never hold, checked at every rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ hw/rtl/etsc_pkg.sv @@
`default_nettype none

package etsc_pkg;

    localparam int BIT_W = 1;

    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
    localparam logic [11:0] CENTURY_20      = 12'd2000;
    localparam logic [4:0]  ZC_19           = 5'd19;
    localparam logic [4:0]  ZC_20           = 5'd20;
    localparam logic [4:0]  ZC_21           = 5'd21;
    localparam logic [11:0] CENTURY_19      = 12'd1900;

    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;
    localparam logic [31:0] YEAR_SECS      = 32'd31536000;
    localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;
    localparam logic [31:0] LEAP_FEB_SECS  = 32'd2505600;

    localparam logic [31:0] MONTH_SECS [12] = '{
        32'd2678400, 32'd2419200, 32'd2678400, 32'd2592000,
        32'd2678400, 32'd2592000, 32'd2678400, 32'd2678400,
        32'd2592000, 32'd2678400, 32'd2592000, 32'd2678400
    };

    localparam logic [3:0] JANUARY    = 4'd1;
    localparam logic [3:0] FEBRUARY   = 4'd2;
    localparam logic [3:0] MARCH      = 4'd3;
    localparam logic [3:0] LAST_MONTH = 4'd12;
    localparam logic [3:0] YEAR_SHIFT = 4'd12;

    // each division is a quotient step then a remainder step
    localparam logic [BIT_W-1:0] DAY_TOP_BIT  = 1'd1;
    localparam logic [BIT_W-1:0] HOUR_TOP_BIT = 1'd1;
    localparam logic [BIT_W-1:0] MIN_TOP_BIT  = 1'd1;

    // reciprocals of 86400 / 128, 3600 / 16 and 60 / 4, exact over each range
    localparam logic [14:0] DAY_RECIP        = 15'd24856;
    localparam int          DAY_RECIP_SHIFT  = 24;
    localparam logic [12:0] HOUR_RECIP       = 13'd4661;
    localparam int          HOUR_RECIP_SHIFT = 20;
    localparam logic [10:0] MIN_RECIP        = 11'd1093;
    localparam int          MIN_RECIP_SHIFT  = 14;

    // 42 is a multiple of 7 and keeps the weekday sum non-negative
    localparam logic [8:0]  ZELLER_BIAS  = 9'd42;
    localparam logic [14:0] RECIP7       = 15'd73;
    localparam int          RECIP7_SHIFT = 9;
    localparam logic [3:0]  WEEK_DAYS    = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_WSUM,
        ST_WMOD,
        ST_OUT
    } etsc_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MIN,
        OP_WSUM,
        OP_WMOD
    } etsc_op_t;

    typedef struct packed {
        etsc_op_t         op;
        logic [BIT_W-1:0] bit_idx;
    } etsc_cmd_t;

    typedef struct packed {
        logic year_end;
        logic month_end;
    } etsc_status_t;

    // valid over 1970..2106, where 2100 is the only century that is not leap
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != NONLEAP_CENTURY);
    endfunction

    function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - JANUARY;
        if (month == FEBRUARY && leap) begin
            return LEAP_FEB_SECS;
        end
        return MONTH_SECS[idx];
    endfunction

    // floor(26 * (m + 1) / 10) for shifted months 3..14
    function automatic logic [5:0] zeller_month_term(input logic [3:0] zm);
        logic [5:0] t;
        case (zm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/etsc_ctrl.sv @@
`default_nettype none

module etsc_ctrl import etsc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire etsc_status_t status,
    output etsc_cmd_t         cmd
);

    etsc_state_t      state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (status.year_end) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (status.month_end) begin
                    state_next = ST_DAY;
                    bit_next   = DAY_TOP_BIT;
                end
            end
            ST_DAY: begin
                if (bit_reg == '0) begin
                    state_next = ST_HOUR;
                    bit_next   = HOUR_TOP_BIT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_HOUR: begin
                if (bit_reg == '0) begin
                    state_next = ST_MIN;
                    bit_next   = MIN_TOP_BIT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_MIN: begin
                if (bit_reg == '0) begin
                    state_next = ST_WSUM;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_WSUM: state_next = ST_WMOD;
            ST_WMOD: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.op      = OP_NONE;
        cmd.bit_idx = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_YEAR:  cmd.op = OP_YEAR;
            ST_MONTH: cmd.op = OP_MONTH;
            ST_DAY:   cmd.op = OP_DAY;
            ST_HOUR:  cmd.op = OP_HOUR;
            ST_MIN:   cmd.op = OP_MIN;
            ST_WSUM:  cmd.op = OP_WSUM;
            ST_WMOD:  cmd.op = OP_WMOD;
            ST_OUT:   m_valid = 1'b1;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/etsc_dp.sv @@
`default_nettype none

module etsc_dp import etsc_pkg::*; (
    input  wire logic        aclk,
    input  wire etsc_cmd_t   cmd,
    input  wire logic [31:0] seconds_in,
    output etsc_status_t     status,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [2:0]       weekday
);

    logic [31:0] rest_reg, rest_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  dayq_reg, dayq_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [7:0]  wsum_reg, wsum_next;
    logic [2:0]  weekday_reg, weekday_next;

    logic        leap;
    logic [31:0] ylen;
    logic [31:0] mlen;

    logic [14:0] day_x;
    logic [29:0] day_prod;
    logic [4:0]  day_q;
    logic [12:0] hour_x;
    logic [25:0] hour_prod;
    logic [4:0]  hour_q;
    logic [9:0]  min_x;
    logic [20:0] min_prod;
    logic [5:0]  min_q;
    logic [31:0] quot_back;

    logic [11:0] zyear;
    logic [3:0]  zm;
    logic [4:0]  zc;
    logic [11:0] zbase;
    logic [6:0]  zy2;
    logic [8:0]  zsum;

    logic [14:0] wprod;
    logic [5:0]  wq;
    logic [8:0]  wrem9;
    logic [3:0]  wrem;

    always_ff @(posedge aclk) begin
        rest_reg    <= rest_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        dayq_reg    <= dayq_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        wsum_reg    <= wsum_next;
        weekday_reg <= weekday_next;
    end

    // year and month lengths
    always_comb begin
        leap             = is_leap(year_reg);
        ylen             = leap ? LEAP_YEAR_SECS : YEAR_SECS;
        mlen             = month_secs(month_reg, leap);
        status.year_end  = rest_reg < ylen;
        status.month_end = (month_reg == LAST_MONTH) || (rest_reg < mlen);
    end

    // quotient by reciprocal, then remainder by multiplying back
    always_comb begin
        day_x     = rest_reg[21:7];
        day_prod  = 30'(day_x) * 30'(DAY_RECIP);
        day_q     = day_prod[DAY_RECIP_SHIFT +: 5];
        hour_x    = rest_reg[16:4];
        hour_prod = 26'(hour_x) * 26'(HOUR_RECIP);
        hour_q    = hour_prod[HOUR_RECIP_SHIFT +: 5];
        min_x     = rest_reg[11:2];
        min_prod  = 21'(min_x) * 21'(MIN_RECIP);
        min_q     = min_prod[MIN_RECIP_SHIFT +: 6];
        case (cmd.op)
            OP_DAY:  quot_back = 32'(dayq_reg) * SECS_PER_DAY;
            OP_HOUR: quot_back = 32'(hour_reg) * SECS_PER_HOUR;
            default: quot_back = 32'(minute_reg) * SECS_PER_MIN;
        endcase
    end

    // weekday sum
    always_comb begin
        if (month_reg < MARCH) begin
            zyear = year_reg - 12'd1;
            zm    = month_reg + YEAR_SHIFT;
        end else begin
            zyear = year_reg;
            zm    = month_reg;
        end
        if (zyear >= NONLEAP_CENTURY) begin
            zc    = ZC_21;
            zbase = NONLEAP_CENTURY;
        end else if (zyear >= CENTURY_20) begin
            zc    = ZC_20;
            zbase = CENTURY_20;
        end else begin
            zc    = ZC_19;
            zbase = CENTURY_19;
        end
        zy2  = 7'(zyear - zbase);
        zsum = 9'(zy2) + 9'(zy2 >> 2) + 9'(zc >> 2) + ZELLER_BIAS - 9'({zc, 1'b0})
             + 9'(zeller_month_term(zm)) + 9'(dayq_reg);
    end

    // mod 7 by reciprocal with one correction
    always_comb begin
        wprod = 15'(wsum_reg) * RECIP7;
        wq    = wprod[RECIP7_SHIFT +: 6];
        wrem9 = {1'b0, wsum_reg} - ({wq, 3'b000} - {3'b000, wq});
        wrem  = wrem9[3:0];
    end

    always_comb begin
        rest_next    = rest_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        dayq_next    = dayq_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        wsum_next    = wsum_reg;
        weekday_next = weekday_reg;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                rest_next   = seconds_in;
                year_next   = EPOCH_YEAR;
                month_next  = JANUARY;
                dayq_next   = '0;
                hour_next   = '0;
                minute_next = '0;
            end
            OP_YEAR: begin
                if (!status.year_end) begin
                    rest_next = rest_reg - ylen;
                    year_next = year_reg + 12'd1;
                end
            end
            OP_MONTH: begin
                if (!status.month_end) begin
                    rest_next  = rest_reg - mlen;
                    month_next = month_reg + 4'd1;
                end
            end
            OP_DAY: begin
                if (cmd.bit_idx == DAY_TOP_BIT) begin
                    dayq_next = day_q;
                end else begin
                    rest_next = rest_reg - quot_back;
                end
            end
            OP_HOUR: begin
                if (cmd.bit_idx == HOUR_TOP_BIT) begin
                    hour_next = hour_q;
                end else begin
                    rest_next = rest_reg - quot_back;
                end
            end
            OP_MIN: begin
                if (cmd.bit_idx == MIN_TOP_BIT) begin
                    minute_next = min_q;
                end else begin
                    rest_next = rest_reg - quot_back;
                end
            end
            OP_WSUM: wsum_next = zsum[7:0];
            OP_WMOD: weekday_next = (wrem >= WEEK_DAYS) ? 3'(wrem - WEEK_DAYS) : wrem[2:0];
            default: begin
            end
        endcase
    end

    assign year    = year_reg;
    assign month   = month_reg;
    assign day     = dayq_reg + 5'd1;
    assign hour    = hour_reg;
    assign minute  = minute_reg;
    assign second  = rest_reg[5:0];
    assign weekday = weekday_reg;

endmodule

`default_nettype wire

@@ hw/rtl/epoch_seconds_to_calendar.sv @@
// channel  | ports                                 | beat
// ---------+---------------------------------------+-----------------------------------------
// input    | s_valid s_ready s_seconds_since_epoch | one 32-bit epoch second count
// result   | m_valid m_ready m_year .. m_weekday   | year month day hour minute second weekday
//
// one beat in flight: after input accept the controller runs the year loop, the
// month loop, then day, hour and minute, the weekday sum and mod, then m_valid;
// the year loop removes one whole year per cycle through a single 32-bit subtract
// and compare; day, hour and minute each take a reciprocal quotient, then remainder
// s_ready is high only while idle; the result holds on m_* until m_ready
// aresetn is synchronous, active low, and returns the controller to idle
`default_nettype none

`include "assert_macros.svh"

module epoch_seconds_to_calendar import etsc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_seconds_since_epoch,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day,
    output logic [4:0]       m_hour,
    output logic [5:0]       m_minute,
    output logic [5:0]       m_second,
    output logic [2:0]       m_weekday
);

    etsc_cmd_t    cmd;
    etsc_status_t status;

    etsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    etsc_dp u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .seconds_in (s_seconds_since_epoch),
        .status     (status),
        .year       (m_year),
        .month      (m_month),
        .day        (m_day),
        .hour       (m_hour),
        .minute     (m_minute),
        .second     (m_second),
        .weekday    (m_weekday)
    );

    `ASSERT_NEVER(a_ready_and_valid, aclk, aresetn, s_ready && m_valid, "ready while result held")
    `ASSERT_CLK(a_no_early_result, aclk, aresetn, (s_valid && s_ready) |=> !m_valid, "result too early")
    `ASSERT_CLK(a_result_range, aclk, aresetn, m_valid |-> (m_weekday <= 3'd6 && m_month >= 4'd1 && m_month <= 4'd12 && m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59), "result field out of range")

endmodule

`default_nettype wire

@@ test/epoch_seconds_to_calendar_test.sv @@
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_test;

    localparam int unsigned DAY_SECS    = 86400;
    localparam int unsigned HOUR_SECS   = 3600;
    localparam int unsigned MIN_SECS    = 60;
    localparam int          FIRST_YEAR  = 1970;
    localparam int          LAST_YEAR   = 2106;
    localparam int unsigned RANDOM_ITEMS = 1230;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 200;

    localparam logic [2:0] SUNDAY   = 3'd0;
    localparam logic [2:0] THURSDAY = 3'd4;
    localparam logic [2:0] FRIDAY   = 3'd5;

    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    typedef struct {
        logic [31:0] seconds;
        bit          fixed;
        calendar_t   want;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 25;

    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, THURSDAY}},
        '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, SUNDAY}},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, THURSDAY}},
        '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, FRIDAY}},
        '{32'd1,          1'b0, '0},
        '{32'd59,         1'b0, '0},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd3600,       1'b0, '0},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd946684799,  1'b0, '0},
        '{32'd946684800,  1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd951868800,  1'b0, '0},
        '{32'd978307200,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4107455999, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4291747199, 1'b0, '0},
        '{32'd4291747200, 1'b0, '0},
        '{32'h5555_5555,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_seconds_since_epoch = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [2:0]  m_weekday;

    calendar_t   due_dates [$];
    logic [31:0] due_seconds [$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_stall = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    epoch_seconds_to_calendar u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_seconds_since_epoch (s_seconds_since_epoch),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_year                (m_year),
        .m_month               (m_month),
        .m_day                 (m_day),
        .m_hour                (m_hour),
        .m_minute              (m_minute),
        .m_second              (m_second),
        .m_weekday             (m_weekday)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned month_length(input int y, input int m);
        if (m == 2 && leap_year(y)) begin
            return 29;
        end
        return MONTH_DAYS[m - 1];
    endfunction

    function automatic int unsigned days_in_year(input int y);
        return leap_year(y) ? 366 : 365;
    endfunction

    // start of a month in epoch seconds, wrapping past the 32-bit top
    function automatic logic [31:0] month_start(input int y, input int m);
        logic [31:0] acc;
        acc = '0;
        for (int k = FIRST_YEAR; k < y; k++) begin
            acc += days_in_year(k) * DAY_SECS;
        end
        for (int k = 1; k < m; k++) begin
            acc += month_length(y, k) * DAY_SECS;
        end
        return acc;
    endfunction

    function automatic calendar_t to_calendar(input logic [31:0] secs);
        logic [31:0] left;
        int          yr;
        int          mo;
        int          d;
        int          zy;
        int          zm;
        int          zc;
        int          wsum;
        int          wd;
        calendar_t   c;
        left = secs;
        yr = FIRST_YEAR;
        mo = 1;
        while (left >= days_in_year(yr) * DAY_SECS) begin
            left -= days_in_year(yr) * DAY_SECS;
            yr++;
        end
        while (mo < 12 && left >= month_length(yr, mo) * DAY_SECS) begin
            left -= month_length(yr, mo) * DAY_SECS;
            mo++;
        end
        d = int'(left / DAY_SECS) + 1;
        left = left % DAY_SECS;
        c.year   = yr[11:0];
        c.month  = mo[3:0];
        c.day    = d[4:0];
        c.hour   = 5'(left / HOUR_SECS);
        left     = left % HOUR_SECS;
        c.minute = 6'(left / MIN_SECS);
        c.second = 6'(left % MIN_SECS);
        // zeller with january and february counted as months of the year before
        zy = yr;
        zm = mo;
        if (zm < 3) begin
            zm += 12;
            zy -= 1;
        end
        zc = zy / 100;
        zy = zy % 100;
        wsum = zy + zy / 4 + zc / 4 - 2 * zc + (26 * (zm + 1)) / 10 + d - 1;
        wd = wsum % 7;
        if (wd < 0) begin
            wd += 7;
        end
        c.weekday = wd[2:0];
        return c;
    endfunction

    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [31:0] pick_seconds();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom();
            end
            4, 5, 6: begin
                v = month_start($urandom_range(FIRST_YEAR, LAST_YEAR), $urandom_range(1, 12))
                    + $urandom_range(0, 4 * DAY_SECS) - 2 * DAY_SECS;
            end
            7: begin
                v = ($urandom() / HOUR_SECS) * HOUR_SECS + $urandom_range(0, 2) - 1;
            end
            8: begin
                v = $urandom_range(0, 100_000_000);
            end
            default: begin
                v = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
            end
        endcase
        return v;
    endfunction

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input logic [31:0] secs);
        if (got != want) begin
            flag_error($sformatf("seconds %0d %s got %0d expected %0d", secs, name, got, want));
        end
    endtask

    task automatic send_beat(input logic [31:0] secs, input calendar_t want,
                             input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_seconds_since_epoch <= secs;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        due_dates.push_back(want);
        due_seconds.push_back(secs);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (due_dates.size() != 0);
    endtask

    always @(posedge aclk) begin
        calendar_t   want;
        logic [31:0] secs;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_dates.size() == 0) begin
                    flag_error("result beat with nothing pending");
                end else begin
                    want = due_dates.pop_front();
                    secs = due_seconds.pop_front();
                    check_field("year", m_year, want.year, secs);
                    check_field("month", m_month, want.month, secs);
                    check_field("day", m_day, want.day, secs);
                    check_field("hour", m_hour, want.hour, secs);
                    check_field("minute", m_minute, want.minute, secs);
                    check_field("second", m_second, want.second, secs);
                    check_field("weekday", m_weekday, want.weekday, secs);
                end
                if ($urandom_range(0, 49) == 0) begin
                    rx_calm <= !rx_calm;
                end
            end
            if (rx_stall != 0) begin
                m_ready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else if (!rx_calm && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                rx_stall <= gap_cycles();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] secs;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].seconds,
                      directed_rows[i].fixed ? directed_rows[i].want
                                             : to_calendar(directed_rows[i].seconds),
                      (i < 6) ? 0 : gap_cycles());
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) begin
                drain_results();
            end
            secs = pick_seconds();
            send_beat(secs, to_calendar(secs), tx_calm ? 0 : gap_cycles());
        end

        s_valid <= 1'b0;
        while (due_dates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ epoch_seconds_to_calendar.f @@
+incdir+hw/rtl
hw/rtl/etsc_pkg.sv
hw/rtl/etsc_ctrl.sv
hw/rtl/etsc_dp.sv
hw/rtl/epoch_seconds_to_calendar.sv
test/epoch_seconds_to_calendar_test.sv
